// ===== rtl/rdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// rdiv_pkg
// Shared types, constants and the reciprocal seed table for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rdiv_pkg;

    localparam int unsigned DIVIDEND_W   = 64;
    localparam int unsigned DIVISOR_W    = 32;
    localparam int unsigned QUOTIENT_W   = 33;
    localparam int unsigned REMAINDER_W  = 32;
    localparam int unsigned RECIP_OUT_W  = 34;
    // Width of the refined reciprocal as carried inside the pipeline.
    localparam int unsigned RECIP_W      = 35;
    // Width of the interpolated seed.
    localparam int unsigned SEED_W       = 34;

    localparam logic [23:0] SEG_MID      = 24'h7F_FFFF;
    localparam logic [6:0]  STEEP_SEGS   = 7'd53;
    localparam int unsigned SLOPE_SHIFT  = 15;

    // Control that travels alongside each request through the stages.
    typedef struct packed {
        logic valid;
        logic err;
    } rdiv_ctl_t;

    // Word 2*i is the base of segment i; word 2*i+1 holds the lower-half slope
    // in bits 15..0 and the upper-half slope in bits 31..16.
    localparam logic [31:0] RCP_ROM [256] = '{
        32'hfe01be73,32'hfa0efe02,32'hfa118cda,32'hf249f625,32'hf630ce32,32'heab1ee77,
        32'hf25f28d1,32'he345e6f6,32'hee9c4562,32'hdc04dfa0,32'heae7cedf,32'hd4edd874,
        32'he7417330,32'hcdfed170,32'he3a8e17f,32'hc736ca95,32'he01dcd03,32'hc094c3e0,
        32'hdc9fea3b,32'hba16bd50,32'hd92eef95,32'hb3bdb6e5,32'hd5ca9688,32'had86b09d,
        32'hd2729981,32'ha771aa78,32'hcf26b64d,32'ha17da473,32'hcbe6aae6,32'h9ba99e8f,
        32'hc8b237ff,32'h95f498cb,32'hc589204f,32'h905d9325,32'hc26b27ab,32'h8ae38d9d,
        32'hbf58143f,32'h85868831,32'hbc4fac82,32'h804582e2,32'hb951b97f,32'h7b1f7daf,
        32'hb65e05d1,32'h76137896,32'hb3745d33,32'h71217397,32'hb0948c50,32'h6c476eb1,
        32'hadbe61e8,32'h678669e4,32'haaf1ada4,32'h62dd652f,32'ha82e40ad,32'h5e4b6091,
        32'ha573ecaf,32'h59cf5c0a,32'ha2c2856d,32'h55695799,32'ha019df1c,32'h5118533e,
        32'h9d79cfcd,32'h4cdd4ef8,32'h9ae22da2,32'h48b54ac6,32'h9852d02e,32'h44a146a9,
        32'h95cb90b5,32'h40a1429f,32'h934c4884,32'h3cb33ea8,32'h90d4d2a6,32'h38d83ac3,
        32'h8e65099f,32'h350f36f1,32'h8bfcca3d,32'h31573331,32'h899bf212,32'h2db02f82,
        32'h87425f4d,32'h2a1a2be3,32'h84eff042,32'h26942855,32'h82a48484,32'h231f24d8,
        32'h805ffd31,32'h1fb82169,32'h7e223a4d,32'h1c611e0b,32'h7beb1f14,32'h19191abb,
        32'h79ba8d10,32'h15df177a,32'h779067d1,32'h12b31447,32'h756c934e,32'h0f951122,
        32'h734ef3ce,32'h0c840e0b,32'h71376ed5,32'h09810b01,32'h6f25e9fb,32'h068b0804,
        32'h6d1a4b55,32'h03a10514,32'h6b1479e7,32'h00c40231,32'h69145d70,32'hfdf2ff59,
        32'h6719dd5a,32'hfb2dfc8e,32'h6524e2c2,32'hf873f9ce,32'h6335561b,32'hf5c4f71a,
        32'h614b2163,32'hf320f471,32'h5f662e94,32'hf088f1d3,32'h5d86681f,32'hedfaef3f,
        32'h5babb887,32'heb76ecb6,32'h59d60b2e,32'he8fcea38,32'h58054c96,32'he68ce7c3,
        32'h5639688f,32'he426e558,32'h54724b96,32'he1cae2f7,32'h52afe2fe,32'hdf77e09f,
        32'h50f21bc9,32'hdd2dde51,32'h4f38e452,32'hdaecdc0b,32'h4d842a0e,32'hd8b3d9cf,
        32'h4bd3dc5a,32'hd684d79b,32'h4a27e9dc,32'hd45dd56f,32'h4880415e,32'hd23ed34c,
        32'h46dcd2ba,32'hd027d131,32'h453d8df4,32'hce18cf1e,32'h43a2630f,32'hcc11cd13,
        32'h420b4269,32'hca11cb10,32'h40781d76,32'hc819c914,32'h3ee8e49a,32'hc628c720,
        32'h3d5d89d3,32'hc43fc533,32'h3bd5fe6d,32'hc25cc34d,32'h3a5234b6,32'hc081c16e,
        32'h38d21e75,32'hbeacbf96,32'h3755aec4,32'hbcdebdc4,32'h35dcd7e8,32'hbb16bbf9,
        32'h34678cbf,32'hb955ba35,32'h32f5c0f8,32'hb79ab877,32'h318767ed,32'hb5e5b6bf,
        32'h301c7585,32'hb437b50d,32'h2eb4dcca,32'hb28eb362,32'h2d5092f9,32'hb0ebb1bc,
        32'h2bef8bfa,32'haf4eb01c,32'h2a91bc94,32'hadb7ae82,32'h2937195c,32'hac25aced,
        32'h27df970e,32'haa98ab5e,32'h268b2ba0,32'ha911a9d4,32'h2539cbff,32'ha78fa84f,
        32'h23eb6d84,32'ha612a6d0,32'h22a006aa,32'ha49aa555,32'h21578c79,32'ha327a3e0,
        32'h2011f59b,32'ha1b9a270,32'h1ecf388e,32'ha050a104,32'h1d8f4b94,32'h9eec9f9d,
        32'h1c5224eb,32'h9d8c9e3b,32'h1b17bb87,32'h9c309cde,32'h19e0073f,32'h9ada9b84,
        32'h18aafd9a,32'h99879a30,32'h17789704,32'h983998e0,32'h1648caa2,32'h96ef9794,
        32'h151b9001,32'h95a9964c,32'h13f0deea,32'h94689508,32'h12c8aef3,32'h932a93c8,
        32'h11a2f800,32'h91f1928d,32'h107fb258,32'h90bb9155,32'h0f5ed663,32'h8f899021,
        32'h0e405c34,32'h8e5b8ef1,32'h0d243c18,32'h8d308dc5,32'h0c0a6f45,32'h8c0a8c9d,
        32'h0af2edf2,32'h8ae68b78,32'h09ddb19b,32'h89c78a56,32'h08cab299,32'h88ab8938,
        32'h07b9e9d5,32'h8792881e,32'h06ab5148,32'h867d8707,32'h059ee1bc,32'h856b85f3,
        32'h0494945c,32'h845c84e3,32'h038c62ff,32'h835083d6,32'h0286478b,32'h824882cc,
        32'h01823b26,32'h814281c5,32'h00803807,32'h804080c1
    };

endpackage

`default_nettype wire

// ===== rtl/rdiv_if.sv =====
// ----------------------------------------------------------------------------
// rdiv_req_if / rdiv_rsp_if
// Valid/ready channels carrying division requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdiv_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] dividend;
    logic [31:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface rdiv_rsp_if;
    logic        valid;
    logic        ready;
    logic [32:0] quotient;
    logic [31:0] remainder;
    logic [33:0] reciprocal;
    logic        divisor_error;

    modport source (output valid, output quotient, output remainder, output reciprocal,
                    output divisor_error, input ready);
    modport sink   (input valid, input quotient, input remainder, input reciprocal,
                    input divisor_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/rdiv_recip.sv =====
// ----------------------------------------------------------------------------
// rdiv_recip
// Seven-stage reciprocal pipeline: table seed, interpolation, one Newton step.
// ----------------------------------------------------------------------------
`default_nettype none

module rdiv_recip (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire rdiv_pkg::rdiv_ctl_t ctl_in,
    input  wire logic [63:0]         dividend_in,
    input  wire logic [31:0]         divisor_in,
    output rdiv_pkg::rdiv_ctl_t      ctl_out,
    output logic [63:0]              dividend_out,
    output logic [31:0]              divisor_out,
    output logic [34:0]              recip_out
);

    localparam int unsigned NSTG = 7;

    rdiv_pkg::rdiv_ctl_t ctl_reg [NSTG];
    logic [63:0]         a_reg   [NSTG];
    logic [31:0]         d_reg   [NSTG];

    // Stage 1: table lookup and segment offset.
    logic [6:0]  seg;
    logic [23:0] frac;
    logic        below_next;
    logic [23:0] mag_next;
    logic [31:0] slopes;
    logic [16:0] slope_next;
    logic [31:0] base_next;
    logic        below_reg;
    logic [23:0] mag_reg;
    logic [16:0] slope_reg;
    logic [31:0] base_reg;

    // Stage 2: slope product.
    logic [40:0] p_reg;
    logic        below2_reg;
    logic [31:0] base2_reg;

    // Stage 3: interpolated seed.
    logic [41:0] p_up;
    logic [33:0] r_next;
    logic [33:0] r_reg;
    logic [33:0] r4_reg;
    logic [33:0] r5_reg;
    logic [33:0] r6_reg;

    // Stage 4: seed times divisor.
    logic [65:0] rd_reg;

    // Stage 5: error term of the Newton step.
    logic [67:0] t_next;
    logic [63:0] e_reg;
    logic        hinz_reg;
    logic        hinz6_reg;

    // Stage 6 and 7: seed times error term in two halves, then the sum.
    logic [65:0] pl_reg;
    logic [65:0] ph_reg;
    logic [97:0] full;
    logic [34:0] rc_next;
    logic [34:0] rc_reg;

    always_comb
    begin
        seg        = divisor_in[30:24];
        frac       = divisor_in[23:0];
        below_next = frac < rdiv_pkg::SEG_MID;
        mag_next   = below_next ? (rdiv_pkg::SEG_MID - frac) : (frac - rdiv_pkg::SEG_MID);
        slopes     = rdiv_pkg::RCP_ROM[{seg, 1'b1}];
        base_next  = rdiv_pkg::RCP_ROM[{seg, 1'b0}];
        slope_next = {(seg < rdiv_pkg::STEEP_SEGS),
                      (below_next ? slopes[15:0] : slopes[31:16])};
    end

    always_comb
    begin
        p_up = {1'b0, p_reg} + 42'd32767;
        if (below2_reg)
        begin
            r_next = {2'b01, base2_reg} + {7'd0, p_up[41:rdiv_pkg::SLOPE_SHIFT]};
        end
        else
        begin
            r_next = {2'b01, base2_reg} - {8'd0, p_reg[40:rdiv_pkg::SLOPE_SHIFT]};
        end
    end

    // X = 2^65 + (d >> 1) - r*d; a negative value wraps to a nonzero top word.
    assign t_next = 68'h2_0000_0000_0000_0000 + {37'd0, d_reg[3][31:1]} - {2'd0, rd_reg};

    always_comb
    begin
        full    = {32'd0, pl_reg} + {ph_reg, 32'd0};
        rc_next = {1'b0, full[97:64]} + (hinz6_reg ? {1'b0, r6_reg} : 35'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < NSTG; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= dividend_in;
            d_reg[0] <= divisor_in;
            for (int i = 1; i < NSTG; i++)
            begin
                a_reg[i] <= a_reg[i-1];
                d_reg[i] <= d_reg[i-1];
            end
            below_reg  <= below_next;
            mag_reg    <= mag_next;
            slope_reg  <= slope_next;
            base_reg   <= base_next;
            p_reg      <= {24'd0, slope_reg} * {17'd0, mag_reg};
            below2_reg <= below_reg;
            base2_reg  <= base_reg;
            r_reg      <= r_next;
            rd_reg     <= {32'd0, r_reg} * {34'd0, d_reg[2]};
            r4_reg     <= r_reg;
            e_reg      <= t_next[63:0];
            hinz_reg   <= t_next[67:64] != 4'd0;
            r5_reg     <= r4_reg;
            pl_reg     <= {32'd0, r5_reg} * {34'd0, e_reg[31:0]};
            ph_reg     <= {32'd0, r5_reg} * {34'd0, e_reg[63:32]};
            hinz6_reg  <= hinz_reg;
            r6_reg     <= r5_reg;
            rc_reg     <= rc_next;
        end
    end

    assign ctl_out      = ctl_reg[NSTG-1];
    assign dividend_out = a_reg[NSTG-1];
    assign divisor_out  = d_reg[NSTG-1];
    assign recip_out    = rc_reg;

endmodule

`default_nettype wire

// ===== rtl/rdiv_quot.sv =====
// ----------------------------------------------------------------------------
// rdiv_quot
// Four-stage quotient pipeline: estimate, back-multiply and one-step fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module rdiv_quot (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire rdiv_pkg::rdiv_ctl_t ctl_in,
    input  wire logic [63:0]         dividend_in,
    input  wire logic [31:0]         divisor_in,
    input  wire logic [34:0]         recip_in,
    output rdiv_pkg::rdiv_ctl_t      ctl_out,
    output logic [32:0]              quotient,
    output logic [31:0]              remainder,
    output logic [33:0]              reciprocal
);

    localparam int unsigned NSTG = 4;

    rdiv_pkg::rdiv_ctl_t ctl_reg [NSTG];
    logic [63:0]         a_reg   [NSTG-1];
    logic [31:0]         d_reg   [NSTG-1];
    logic [34:0]         rc_reg  [NSTG-1];

    logic [66:0] pa_reg;
    logic [66:0] pb_reg;
    logic [98:0] qsum;
    logic [34:0] q_reg;
    logic [34:0] q2_reg;
    logic [66:0] qd_full;
    logic [63:0] qd_reg;

    logic [63:0] diff;
    logic [34:0] q_fix;
    logic [63:0] r_fix;

    logic [32:0] quot_reg;
    logic [31:0] rem_reg;
    logic [33:0] recip_reg;

    assign qsum    = {32'd0, pa_reg} + {pb_reg, 32'd0};
    assign qd_full = {32'd0, q_reg} * {35'd0, d_reg[1]};

    always_comb
    begin
        diff = a_reg[2] - qd_reg;
        priority if (diff[63])
        begin
            q_fix = q2_reg - 35'd1;
            r_fix = diff + {32'd0, d_reg[2]};
        end
        else if (diff >= {32'd0, d_reg[2]})
        begin
            q_fix = q2_reg + 35'd1;
            r_fix = diff - {32'd0, d_reg[2]};
        end
        else
        begin
            q_fix = q2_reg;
            r_fix = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < NSTG; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]  <= dividend_in;
            d_reg[0]  <= divisor_in;
            rc_reg[0] <= recip_in;
            for (int i = 1; i < NSTG - 1; i++)
            begin
                a_reg[i]  <= a_reg[i-1];
                d_reg[i]  <= d_reg[i-1];
                rc_reg[i] <= rc_reg[i-1];
            end
            pa_reg <= {32'd0, dividend_in[31:0]} * {32'd0, recip_in};
            pb_reg <= {32'd0, dividend_in[63:32]} * {32'd0, recip_in};
            q_reg  <= qsum[98:64];
            q2_reg <= q_reg;
            qd_reg <= qd_full[63:0];
            // An out-of-range divisor forces every numeric field to zero.
            if (ctl_reg[2].err)
            begin
                quot_reg  <= '0;
                rem_reg   <= '0;
                recip_reg <= '0;
            end
            else
            begin
                quot_reg  <= q_fix[32:0];
                rem_reg   <= r_fix[31:0];
                recip_reg <= rc_reg[2][33:0];
            end
        end
    end

    assign ctl_out    = ctl_reg[NSTG-1];
    assign quotient   = quot_reg;
    assign remainder  = rem_reg;
    assign reciprocal = recip_reg;

endmodule

`default_nettype wire

// ===== rtl/reciprocal_divider_64_by_32.sv =====
// ----------------------------------------------------------------------------
// reciprocal_divider_64_by_32
// Pipelined 64-by-32 divider using a table-seeded, Newton-refined reciprocal.
// ----------------------------------------------------------------------------
//
//   Port  Direction  Carries
//   ----  ---------  ----------------------------------------------------------
//   req   sink       dividend (64 b), divisor (32 b, bit 31 expected set)
//   rsp   source     quotient (33 b), remainder (32 b), reciprocal (34 b),
//                    divisor_error (1 b)
//
// Every request passes eleven register stages, seven in the reciprocal unit
// and four in the quotient unit, before its result is offered. A new request
// is taken on every cycle in which the output is empty or its result taken.
// The stages share one advance enable, which drops only while the final stage
// holds a result that the sink has not taken, so a stall freezes every stage
// in place and nothing is dropped or repeated.
// Reset clears the stage valid bits; the datapath registers are not reset.
//
`default_nettype none

module reciprocal_divider_64_by_32 (
    input wire logic clk,
    input wire logic rst_n,
    rdiv_req_if.sink   req,
    rdiv_rsp_if.source rsp
);

    logic                en;
    rdiv_pkg::rdiv_ctl_t ctl_in;
    rdiv_pkg::rdiv_ctl_t ctl_mid;
    rdiv_pkg::rdiv_ctl_t ctl_last;
    logic [63:0]         a_mid;
    logic [31:0]         d_mid;
    logic [34:0]         rc_mid;

    // The whole pipeline moves whenever the output register is empty or its
    // result is being taken this cycle.
    assign en        = !ctl_last.valid || rsp.ready;
    assign req.ready = en;

    // A divisor without its top bit set is outside the supported range and is
    // flagged; it still travels the pipeline so that ordering is kept.
    assign ctl_in.valid = req.valid;
    assign ctl_in.err   = !req.divisor[31];

    rdiv_recip u_recip (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .ctl_in       (ctl_in),
        .dividend_in  (req.dividend),
        .divisor_in   (req.divisor),
        .ctl_out      (ctl_mid),
        .dividend_out (a_mid),
        .divisor_out  (d_mid),
        .recip_out    (rc_mid)
    );

    rdiv_quot u_quot (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctl_in      (ctl_mid),
        .dividend_in (a_mid),
        .divisor_in  (d_mid),
        .recip_in    (rc_mid),
        .ctl_out     (ctl_last),
        .quotient    (rsp.quotient),
        .remainder   (rsp.remainder),
        .reciprocal  (rsp.reciprocal)
    );

    assign rsp.valid         = ctl_last.valid;
    assign rsp.divisor_error = ctl_last.err;

    // A flagged result must carry zeros in every numeric field.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.divisor_error |->
            rsp.quotient == '0 && rsp.remainder == '0 && rsp.reciprocal == '0)
    else $error("divisor error result carries nonzero fields");

    // The input side may only be held off by an untaken result at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready == (!rsp.valid || rsp.ready))
    else $error("input ready does not follow output occupancy");

    // A stalled result must not let a new request in on the same edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request accepted while the output is stalled");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 64-by-32 reciprocal divider: directed table
// followed by random requests, checked against a bit-true predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    // One expected result, as it should appear on the result channel.
    typedef struct packed {
        logic [32:0] quotient;
        logic [31:0] remainder;
        logic [33:0] reciprocal;
        logic        divisor_error;
    } div_result_t;

    // A row of the directed table. Where has_known is set, the expected result
    // is typed in and must also agree with the predictor.
    typedef struct {
        logic [63:0] dividend;
        logic [31:0] divisor;
        bit          has_known;
        div_result_t known;
    } div_row_t;

    localparam int RANDOM_REQUESTS = 650;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic clk;
    logic rst_n;
    int   failures;
    int   idle_cycles;
    bit   stimulus_done;

    div_result_t pending_results[$];
    div_row_t    directed_rows[$];

    rdiv_req_if req ();
    rdiv_rsp_if rsp ();

    reciprocal_divider_64_by_32 dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Full 64 by 64 product, giving the upper and lower halves.
    function automatic logic [127:0] wide_product(logic [63:0] x, logic [63:0] y);
        return {64'd0, x} * {64'd0, y};
    endfunction

    // Interpolated seed of 2^64/divisor followed by one Newton step.
    function automatic logic [63:0] refine_reciprocal(logic [31:0] d);
        logic [6:0]   seg;
        logic [23:0]  frac;
        bit           below;
        logic [63:0]  mag;
        logic [31:0]  slopes;
        logic [63:0]  slope;
        logic [63:0]  seed;
        logic [63:0]  prod;
        logic [127:0] full;
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [63:0]  half;
        logic [63:0]  borrow;
        seg    = d[30:24];
        frac   = d[23:0];
        below  = frac < rdiv_pkg::SEG_MID;
        mag    = below ? 64'(rdiv_pkg::SEG_MID - frac) : 64'(frac - rdiv_pkg::SEG_MID);
        slopes = rdiv_pkg::RCP_ROM[2 * seg + 1];
        slope  = below ? 64'(slopes[15:0]) : 64'(slopes[31:16]);
        if (seg < rdiv_pkg::STEEP_SEGS)
        begin
            slope[16] = 1'b1;
        end
        seed = {31'd0, 1'b1, rdiv_pkg::RCP_ROM[2 * seg]};
        prod = slope * mag;
        if (below)
        begin
            seed = seed + ((prod + 64'h7FFF) >> rdiv_pkg::SLOPE_SHIFT);
        end
        else
        begin
            seed = seed - (prod >> rdiv_pkg::SLOPE_SHIFT);
        end
        // The error term 2^65 + d/2 - seed*d, kept as two 64-bit halves.
        full   = wide_product(seed, {32'd0, d});
        half   = {33'd0, d[31:1]};
        borrow = (half < full[63:0]) ? 64'd1 : 64'd0;
        lo     = half - full[63:0];
        hi     = 64'd2 - full[127:64] - borrow;
        full   = wide_product(seed, lo);
        return full[127:64] + ((hi != 64'd0) ? seed : 64'd0);
    endfunction

    function automatic div_result_t predict_division(logic [63:0] a, logic [31:0] d);
        div_result_t  res;
        logic [63:0]  recip;
        logic [127:0] full;
        logic [63:0]  q;
        logic [63:0]  diff;
        res = '0;
        if (!d[31])
        begin
            res.divisor_error = 1'b1;
            return res;
        end
        recip = refine_reciprocal(d);
        full  = wide_product(a, recip);
        q     = full[127:64];
        diff  = a - q * {32'd0, d};
        if (diff[63])
        begin
            q    = q - 64'd1;
            diff = diff + {32'd0, d};
        end
        else if (diff >= {32'd0, d})
        begin
            q    = q + 64'd1;
            diff = diff - {32'd0, d};
        end
        res.quotient   = q[32:0];
        res.remainder  = diff[31:0];
        res.reciprocal = recip[33:0];
        return res;
    endfunction

    task automatic add_row(logic [63:0] a, logic [31:0] d, bit known_flag,
                           div_result_t known_res);
        div_row_t row;
        row.dividend  = a;
        row.divisor   = d;
        row.has_known = known_flag;
        row.known     = known_res;
        directed_rows.push_back(row);
    endtask

    // Hands one request to the block, honouring the ready handshake, and files
    // the predicted result once the request has been taken.
    task automatic offer_request(logic [63:0] a, logic [31:0] d);
        req.valid    <= 1'b1;
        req.dividend <= a;
        req.divisor  <= d;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(predict_division(a, d));
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        req.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Random divisor: mostly normalised, now and then below 2^31, with
    // segment edges and the middle of a segment favoured.
    function automatic logic [31:0] pick_divisor();
        logic [31:0] d;
        int          pick;
        d    = $urandom;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            d[31] = 1'b0;
        end
        else
        begin
            d[31] = 1'b1;
            case (pick)
                1: d[23:0] = 24'h00_0000;
                2: d[23:0] = 24'hFF_FFFF;
                3: d[23:0] = rdiv_pkg::SEG_MID;
                4: d[23:0] = rdiv_pkg::SEG_MID + 24'd1;
                default: ;
            endcase
        end
        return d;
    endfunction

    function automatic logic [63:0] pick_dividend();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: a = 64'hFFFF_FFFF_FFFF_FFFF;
            1: a = {32'd0, $urandom};
            2: a = a >> $urandom_range(0, 63);
            default: ;
        endcase
        return a;
    endfunction

    // Request side: directed table first, then random bursts with gaps.
    initial
    begin
        div_result_t err_res;
        div_result_t zero_res;
        div_result_t got;
        int          burst;
        int          sent;
        req.valid     = 1'b0;
        req.dividend  = '0;
        req.divisor   = '0;
        rst_n         = 1'b0;
        failures      = 0;
        stimulus_done = 1'b0;
        err_res       = '0;
        err_res.divisor_error = 1'b1;
        zero_res      = '0;

        // Below 2^31 every output but the error flag is zero.
        add_row(64'd0, 32'd0, 1'b1, err_res);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, err_res);
        add_row(64'h1234_5678_9ABC_DEF0, 32'h0000_0001, 1'b1, err_res);
        // Zero dividend gives zero quotient and remainder; the reciprocal
        // still comes from the predictor.
        add_row(64'd0, 32'h8000_0000, 1'b0, zero_res);
        add_row(64'd0, 32'hFFFF_FFFF, 1'b0, zero_res);
        // Extremes of both fields and the ends of the first and last segment.
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0, zero_res);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_res);
        add_row(64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0001, 1'b0, zero_res);
        add_row(64'h0000_0000_FFFF_FFFF, 32'h8000_0000, 1'b0, zero_res);
        add_row(64'h0000_0001_0000_0000, 32'hFFFF_FFFF, 1'b0, zero_res);
        // The segment midpoint and the value just above it, and either side of the steep-slope boundary.
        add_row(64'hDEAD_BEEF_0BAD_F00D, 32'h807F_FFFF, 1'b0, zero_res);
        add_row(64'hDEAD_BEEF_0BAD_F00D, 32'h8080_0000, 1'b0, zero_res);
        add_row(64'hCAFE_F00D_1234_5678, 32'hB4FF_FFFF, 1'b0, zero_res);
        add_row(64'hCAFE_F00D_1234_5678, 32'hB500_0000, 1'b0, zero_res);
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b1, err_res);
        add_row(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, zero_res);
        add_row(64'h0000_0000_0000_0001, 32'hC000_0000, 1'b0, zero_res);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            got = predict_division(directed_rows[i].dividend, directed_rows[i].divisor);
            if (directed_rows[i].has_known && got != directed_rows[i].known)
            begin
                $display("%0t: table row %0d disagrees with predictor: expected %h, got %h",
                         $time, i, directed_rows[i].known, got);
                failures++;
            end
            offer_request(directed_rows[i].dividend, directed_rows[i].divisor);
        end

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < RANDOM_REQUESTS)
            begin
                offer_request(pick_dividend(), pick_divisor());
                burst--;
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 6));
            end
        end
        req.valid     <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Result side: stalls on a pattern of its own. Early in the random phase
    // one long hold-off lets the pipeline fill up and push back on requests.
    initial
    begin
        int phase;
        rsp.ready = 1'b0;
        phase     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase++;
            if (phase == 120)
            begin
                rsp.ready <= 1'b0;
                repeat (60) @(negedge clk);
            end
            if (phase % 200 < 40)
            begin
                rsp.ready <= 1'b1;
            end
            else
            begin
                rsp.ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // Compare every accepted result with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        div_result_t want;
        div_result_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.quotient, rsp.remainder, rsp.reciprocal, rsp.divisor_error};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.quotient != want.quotient)
                begin
                    $display("%0t: quotient: expected %h, actual %h",
                             $time, want.quotient, got.quotient);
                    failures++;
                end
                if (got.remainder != want.remainder)
                begin
                    $display("%0t: remainder: expected %h, actual %h",
                             $time, want.remainder, got.remainder);
                    failures++;
                end
                if (got.reciprocal != want.reciprocal)
                begin
                    $display("%0t: reciprocal: expected %h, actual %h",
                             $time, want.reciprocal, got.reciprocal);
                    failures++;
                end
                if (got.divisor_error != want.divisor_error)
                begin
                    $display("%0t: divisor_error: expected %b, actual %b",
                             $time, want.divisor_error, got.divisor_error);
                    failures++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Once everything is in and answered, wait out the pipeline depth so that
    // any stray extra result would still be caught, then report.
    initial
    begin
        @(posedge rst_n);
        while (!(stimulus_done && pending_results.size() == 0) &&
               idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
        end
        else
        begin
            repeat (30) @(posedge clk);
            if (failures == 0 && pending_results.size() == 0)
            begin
                $display("SCOREBOARD CLEAN");
            end
            else
            begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
